### src/iamu_pkg.sv
// Shared types, constants and the quarter-wave sine function of the upconverter.
`default_nettype none
package iamu_pkg;

   // Default sizes
   localparam int TAPS_DEF        = 24;
   localparam int MAX_FACTOR_DEF  = 16;
   localparam int SINE_SIZE_DEF   = 1024;

   // Fixed field widths
   localparam int TAP_IDX_W = 9;
   localparam int TAP_W     = 18;
   localparam int SMP_W     = 16;
   localparam int FACTOR_W  = 5;
   localparam int GAIN_W    = 16;
   localparam int PH_W      = 30;
   localparam int CSR_IDX_W = 2;
   localparam int STEP_W    = 5;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd3;

   // Input actions
   localparam logic ACT_TAP    = 1'b0;
   localparam logic ACT_SAMPLE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PH_MOD,
      ST_STEP_MOD,
      ST_TIX_GO,
      ST_TIX,
      ST_MAC,
      ST_ROUND,
      ST_MIX,
      ST_SUM,
      ST_GAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_tap;
      logic take_sample;
      logic take_phase;
      logic start_step;
      logic take_step;
      logic start_tix;
      logic take_tix;
      logic mac_start;
      logic emit;
      logic next_phase;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic mac_done;
      logic out_free;
      logic last_phase;
   } status_type;

   // Sine of u quarter turns (u in Q.30) as a Q1.15 magnitude, series to x^11
   function automatic logic [15:0] quarter_sine(input logic [30:0] u);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      x    = ({33'd0, u} * 64'd1686629713) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      if (sum < 0) sum = 64'sd0;
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32767) r = 64'sd32767;
      return r[15:0];
   endfunction

endpackage
`default_nettype wire

### src/iamu_div.sv
// Restoring divider, one quotient bit per cycle, for phase reduction and table index.
`default_nettype none
module iamu_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [iamu_pkg::PH_W-1:0]   rem_init,
   input  wire logic [iamu_pkg::PH_W-1:0]   num_init,
   input  wire logic [iamu_pkg::STEP_W-1:0] steps,
   input  wire logic [iamu_pkg::PH_W-1:0]   divisor,
   output logic                             busy,
   output logic [iamu_pkg::PH_W-1:0]        rem,
   output logic [iamu_pkg::PH_W-1:0]        quot
);
   localparam int W = iamu_pkg::PH_W;

   logic [W-1:0]                  rem_ff, rem_in;
   logic [W-1:0]                  num_ff, num_in;
   logic [iamu_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [W:0]                    trial;
   logic                          ge;

   // Shift in one numerator bit and subtract where it fits
   always_comb begin
      trial  = {rem_ff, num_ff[W-1]};
      ge     = trial >= {1'b0, divisor};
      rem_in = rem_ff;
      num_in = num_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = rem_init;
         num_in = num_init;
         cnt_in = steps;
      end else if (cnt_ff != '0) begin
         rem_in = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
         num_in = {num_ff[W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      if (reset) cnt_ff <= '0;
      else       cnt_ff <= cnt_in;
   end

   assign busy = cnt_ff != '0;
   assign rem  = rem_ff;
   assign quot = num_ff;
endmodule
`default_nettype wire

### src/iamu_dp.sv
// Datapath: registers, tap memory, history, serial MAC, mixer, gain and output register.
`default_nettype none
module iamu_dp #(
   parameter int TAPS_PER_PHASE  = iamu_pkg::TAPS_DEF,
   parameter int MAX_FACTOR      = iamu_pkg::MAX_FACTOR_DEF,
   parameter int SINE_TABLE_SIZE = iamu_pkg::SINE_SIZE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire iamu_pkg::cmd_type                 cmd,
   output iamu_pkg::status_type                   status,
   input  wire logic [iamu_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              csr_valid,
   input  wire logic [iamu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [iamu_pkg::PH_W-1:0]         csr_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [iamu_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast
);
   localparam int DEPTH  = TAPS_PER_PHASE * MAX_FACTOR;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int L_W    = $clog2(MAX_FACTOR + 1);
   localparam int JW     = $clog2(TAPS_PER_PHASE);
   localparam int JC_W   = $clog2(TAPS_PER_PHASE + 1);
   localparam int LN     = $clog2(SINE_TABLE_SIZE);
   localparam int LQ     = LN - 2;
   localparam int QN     = SINE_TABLE_SIZE / 4;
   localparam int PROD_W = iamu_pkg::TAP_W + iamu_pkg::SMP_W;
   localparam int ACC_W  = PROD_W + JW;
   localparam int AI_W   = ACC_W - 15;
   localparam int MP_W   = AI_W + 16;
   localparam int MI_W   = AI_W + 2;
   localparam int G_W    = MI_W + iamu_pkg::GAIN_W + 1;
   localparam int W      = iamu_pkg::PH_W;

   // Input fields
   logic [iamu_pkg::TAP_IDX_W-1:0]    tap_index;
   logic signed [iamu_pkg::TAP_W-1:0] tap_value;
   logic [2*iamu_pkg::SMP_W-1:0]      sample_iq;
   assign tap_index = req_tdata[8:0];
   assign tap_value = req_tdata[26:9];
   assign sample_iq = req_tdata[58:27];

   // Configuration registers
   logic [iamu_pkg::FACTOR_W-1:0] factor_ff;
   logic [iamu_pkg::GAIN_W-1:0]   gain_ff;
   logic [W-1:0]                  rate_ff;
   logic [W-1:0]                  offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= iamu_pkg::FACTOR_W'(1);
         gain_ff   <= iamu_pkg::GAIN_W'(4096);
         rate_ff   <= W'(48000);
         offset_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            iamu_pkg::CSR_FACTOR: factor_ff <= csr_data[iamu_pkg::FACTOR_W-1:0];
            iamu_pkg::CSR_GAIN:   gain_ff   <= csr_data[iamu_pkg::GAIN_W-1:0];
            iamu_pkg::CSR_RATE:   rate_ff   <= csr_data;
            iamu_pkg::CSR_OFFSET: offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective factor and rate
   logic [L_W-1:0] l_eff;
   logic [W-1:0]   rate_eff;
   always_comb begin
      if (factor_ff == '0)                    l_eff = L_W'(1);
      else if (int'(factor_ff) > MAX_FACTOR)  l_eff = L_W'(MAX_FACTOR);
      else                                    l_eff = L_W'(factor_ff);
      rate_eff = (rate_ff == '0) ? W'(1) : rate_ff;
   end

   // Tap memory
   logic signed [iamu_pkg::TAP_W-1:0] coef_mem [DEPTH];
   logic signed [iamu_pkg::TAP_W-1:0] coef_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_tap && (int'(tap_index) < DEPTH))
         coef_mem[ADDR_W'(tap_index)] <= tap_value;
   end

   // Sample history, newest at entry zero
   logic [2*iamu_pkg::SMP_W-1:0] hist_ff [TAPS_PER_PHASE];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS_PER_PHASE; k++) hist_ff[k] <= '0;
      end else if (cmd.take_sample) begin
         hist_ff[0] <= sample_iq;
         for (int k = 1; k < TAPS_PER_PHASE; k++) hist_ff[k] <= hist_ff[k-1];
      end
   end

   // Mixer phase, step and divider
   logic [W-1:0]    phase_ff, step_ff;
   logic [LN-1:0]   tix_ff;
   logic [L_W-1:0]  p_ff;
   logic            div_start, div_busy;
   logic [W-1:0]    div_rem_init, div_num_init, div_rem, div_quot;
   logic [iamu_pkg::STEP_W-1:0] div_steps;
   logic            off_neg;
   logic [W-1:0]    off_abs;
   logic [W:0]      phase_sum;

   assign off_neg = offset_ff[W-1];
   assign off_abs = off_neg ? W'(-offset_ff) : offset_ff;

   always_comb begin
      div_start    = cmd.take_sample | cmd.start_step | cmd.start_tix;
      div_rem_init = cmd.start_tix ? phase_ff : '0;
      div_num_init = cmd.take_sample ? phase_ff : (cmd.start_step ? off_abs : '0);
      div_steps    = cmd.start_tix ? iamu_pkg::STEP_W'(LN) : iamu_pkg::STEP_W'(W);
   end

   iamu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .num_init (div_num_init),
      .steps    (div_steps),
      .divisor  (rate_eff),
      .busy     (div_busy),
      .rem      (div_rem),
      .quot     (div_quot)
   );

   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (cmd.take_phase) begin
         phase_ff <= div_rem;
      end else if (cmd.next_phase) begin
         phase_ff <= (phase_sum >= {1'b0, rate_eff}) ?
                     W'(phase_sum - {1'b0, rate_eff}) : phase_sum[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_step)
         step_ff <= (off_neg && (div_rem != '0)) ? W'(rate_eff - div_rem) : div_rem;
      if (cmd.take_tix)
         tix_ff <= div_quot[LN-1:0];
   end

   // Output phase counter
   always_ff @(posedge clock) begin
      if (cmd.take_sample)     p_ff <= '0;
      else if (cmd.next_phase) p_ff <= p_ff + 1'b1;
   end

   // Serial MAC: one tap read per cycle, accumulated in the cycle after its read
   logic [JC_W-1:0]          j_ff;
   logic [JW-1:0]            jd_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic                     rd_valid_ff;
   logic                     rd_en;
   logic signed [ACC_W-1:0]  acc_i_ff, acc_q_ff;
   logic signed [iamu_pkg::SMP_W-1:0] x_i, x_q;

   assign rd_en = int'(j_ff) < TAPS_PER_PHASE;
   assign x_i   = hist_ff[jd_ff][15:0];
   assign x_q   = hist_ff[jd_ff][31:16];

   always_ff @(posedge clock) begin
      if (rd_en) coef_rd_ff <= coef_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff        <= JC_W'(TAPS_PER_PHASE);
         rd_valid_ff <= 1'b0;
      end else if (cmd.mac_start) begin
         j_ff        <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         if (rd_en) j_ff <= j_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_start) begin
         addr_ff  <= ADDR_W'(p_ff);
         acc_i_ff <= '0;
         acc_q_ff <= '0;
      end else begin
         if (rd_en) begin
            addr_ff <= addr_ff + ADDR_W'(l_eff);
            jd_ff   <= j_ff[JW-1:0];
         end
         if (rd_valid_ff) begin
            acc_i_ff <= acc_i_ff + ACC_W'(coef_rd_ff * x_i);
            acc_q_ff <= acc_q_ff + ACC_W'(coef_rd_ff * x_q);
         end
      end
   end

   // Quarter-wave sine table
   logic [15:0] qtab [QN+1];
   for (genvar k = 0; k <= QN; k++) begin : g_qtab
      localparam logic [15:0] QV = iamu_pkg::quarter_sine(31'(k * (2 ** (30 - LQ))));
      assign qtab[k] = QV;
   end

   logic [LN-1:0]  cix;
   logic [LQ:0]    sidx, cidx;
   logic signed [15:0] sin_v, cos_v;
   always_comb begin
      cix   = tix_ff + LN'(QN);
      sidx  = tix_ff[LN-2] ? ((LQ+1)'(QN) - {1'b0, tix_ff[LQ-1:0]}) : {1'b0, tix_ff[LQ-1:0]};
      cidx  = cix[LN-2] ? ((LQ+1)'(QN) - {1'b0, cix[LQ-1:0]}) : {1'b0, cix[LQ-1:0]};
      sin_v = tix_ff[LN-1] ? -signed'(qtab[sidx]) : signed'(qtab[sidx]);
      cos_v = cix[LN-1] ? -signed'(qtab[cidx]) : signed'(qtab[cidx]);
   end

   // Round, mix, gain: free-running stages, inputs hold while the controller waits
   logic signed [AI_W-1:0] ai_ff, aq_ff;
   logic signed [15:0]     c_ff, s_ff;
   logic signed [MP_W-1:0] ic_ff, qs_ff, is_ff, qc_ff;
   logic signed [MI_W-1:0] mi_ff, mq_ff;
   logic signed [G_W-1:0]  gi_ff, gq_ff;
   logic signed [MP_W:0]   mi_full, mq_full;
   logic signed [G_W-1:0]  yi_full, yq_full;
   logic signed [iamu_pkg::GAIN_W:0] gain_s;

   assign gain_s  = signed'({1'b0, gain_ff});
   assign mi_full = (MP_W+1)'(ic_ff) - (MP_W+1)'(qs_ff) + (MP_W+1)'(16384);
   assign mq_full = (MP_W+1)'(is_ff) + (MP_W+1)'(qc_ff) + (MP_W+1)'(16384);
   assign yi_full = (gi_ff + G_W'(2048)) >>> 12;
   assign yq_full = (gq_ff + G_W'(2048)) >>> 12;

   always_ff @(posedge clock) begin
      ai_ff <= AI_W'((ACC_W+1)'(acc_i_ff) + (ACC_W+1)'(32768) >>> 16);
      aq_ff <= AI_W'((ACC_W+1)'(acc_q_ff) + (ACC_W+1)'(32768) >>> 16);
      c_ff  <= cos_v;
      s_ff  <= sin_v;
      ic_ff <= MP_W'(ai_ff * c_ff);
      qs_ff <= MP_W'(aq_ff * s_ff);
      is_ff <= MP_W'(ai_ff * s_ff);
      qc_ff <= MP_W'(aq_ff * c_ff);
      mi_ff <= MI_W'(mi_full >>> 15);
      mq_ff <= MI_W'(mq_full >>> 15);
      gi_ff <= G_W'(mi_ff * gain_s);
      gq_ff <= G_W'(mq_ff * gain_s);
   end

   function automatic logic [15:0] sat16(input logic signed [G_W-1:0] v);
      if (v > G_W'(32767))       return 16'h7FFF;
      else if (v < -G_W'(32768)) return 16'h8000;
      else                       return v[15:0];
   endfunction

   // Output register
   logic                           rsp_valid_ff;
   logic [iamu_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                           rsp_last_ff;
   logic                           last_phase;

   assign last_phase = p_ff == (l_eff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.emit)      rsp_valid_ff <= 1'b1;
      else if (rsp_tready)    rsp_valid_ff <= 1'b0;
      if (cmd.emit) begin
         rsp_data_ff <= {sat16(yq_full), sat16(yi_full)};
         rsp_last_ff <= last_phase;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      status.div_busy   = div_busy;
      status.mac_done   = (int'(j_ff) == TAPS_PER_PHASE) && !rd_valid_ff;
      status.out_free   = !rsp_valid_ff || rsp_tready;
      status.last_phase = last_phase;
   end

`ifndef SYNTHESIS
   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.next_phase |=> phase_ff < rate_eff) else $error("mixer phase left its range");
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.take_step |=> step_ff < rate_eff) else $error("mixer step left its range");
   a_tap_addr: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> int'(addr_ff) < DEPTH) else $error("tap read beyond store");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready)) else $error("output overwritten");
`endif
endmodule
`default_nettype wire

### src/iamu_ctrl.sv
// Controller: takes tap loads and sequences phase reduction, per-output index, MAC, mixing and emit.
`default_nettype none
module iamu_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tuser,
   output logic                      req_tready,
   input  wire iamu_pkg::status_type status,
   output iamu_pkg::cmd_type         cmd
);
   iamu_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= iamu_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         iamu_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == iamu_pkg::ACT_SAMPLE) begin
                  cmd.take_sample = 1'b1;
                  state_in        = iamu_pkg::ST_PH_MOD;
               end else begin
                  cmd.load_tap = 1'b1;
               end
            end
         end
         iamu_pkg::ST_PH_MOD: begin
            if (!status.div_busy) begin
               cmd.take_phase = 1'b1;
               cmd.start_step = 1'b1;
               state_in       = iamu_pkg::ST_STEP_MOD;
            end
         end
         iamu_pkg::ST_STEP_MOD: begin
            if (!status.div_busy) begin
               cmd.take_step = 1'b1;
               state_in      = iamu_pkg::ST_TIX_GO;
            end
         end
         iamu_pkg::ST_TIX_GO: begin
            cmd.start_tix = 1'b1;
            state_in      = iamu_pkg::ST_TIX;
         end
         iamu_pkg::ST_TIX: begin
            if (!status.div_busy) begin
               cmd.take_tix  = 1'b1;
               cmd.mac_start = 1'b1;
               state_in      = iamu_pkg::ST_MAC;
            end
         end
         iamu_pkg::ST_MAC:   if (status.mac_done) state_in = iamu_pkg::ST_ROUND;
         iamu_pkg::ST_ROUND: state_in = iamu_pkg::ST_MIX;
         iamu_pkg::ST_MIX:   state_in = iamu_pkg::ST_SUM;
         iamu_pkg::ST_SUM:   state_in = iamu_pkg::ST_GAIN;
         iamu_pkg::ST_GAIN:  state_in = iamu_pkg::ST_EMIT;
         iamu_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.next_phase = 1'b1;
               state_in = status.last_phase ? iamu_pkg::ST_IDLE : iamu_pkg::ST_TIX_GO;
            end
         end
         default: state_in = iamu_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

### src/interpolate_and_mix_upconverter.sv
// Top level of the polyphase interpolator with complex mixer, gain and saturation.
//
//  channel | direction | transaction
//  req_    | in        | tuser=action; tdata: tap_index, tap_value, sample_i, sample_q
//  rsp_    | out       | tdata: out_i, out_q; tlast = last output of a run
//  csr_    | in        | csr_index selects factor, gain, sample_rate, frequency_offset
//
//  A tap load is written while the controller stays idle. A sample is accepted in the
//  idle state, then the phase and step are reduced in the serial divider; per output
//  follow the index division, a serial MAC over the single tap memory, and then
//  rounding, mixing, summing and gain. A stalled result holds the controller
//  in its emit state. Reset is synchronous and clears the history and mixer phase.
`default_nettype none
module interpolate_and_mix_upconverter #(
   parameter int TAPS_PER_PHASE  = iamu_pkg::TAPS_DEF,
   parameter int MAX_FACTOR      = iamu_pkg::MAX_FACTOR_DEF,
   parameter int SINE_TABLE_SIZE = iamu_pkg::SINE_SIZE_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [8:0] tap_index, [26:9] tap_value, [42:27] sample_i, [58:43] sample_q
   input  wire logic [iamu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] action
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] out_i, [31:16] out_q
   output logic [iamu_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tlast,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [iamu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [iamu_pkg::PH_W-1:0]         csr_data
);
   iamu_pkg::cmd_type    cmd;
   iamu_pkg::status_type status;

   assign csr_ready = 1'b1;

   iamu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   iamu_dp #(
      .TAPS_PER_PHASE  (TAPS_PER_PHASE),
      .MAX_FACTOR      (MAX_FACTOR),
      .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire
